// File: rtl/sfp_pkg.sv
// ============================================================================
// sfp_pkg
// Shared types and constants for the sensor frame parser with moving sum.
// ============================================================================
package sfp_pkg;

    // Frame layout: sync byte, eleven data bytes, one checksum byte.
    localparam int unsigned FRAME_HIST = 12;
    localparam int unsigned SKIP_LEN   = 12;
    localparam int unsigned SUM_W      = 22;

    // Default ring length and register reset values.
    localparam int unsigned WINDOW_SAMPLES_DEF = 20;
    localparam logic [7:0]  SYNC_RESET         = 8'hFF;
    localparam logic [7:0]  QLIMIT_RESET       = 8'd15;

    // APB port geometry.
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    // Request kinds on the input channel.
    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_QUERY   = 2'd1,
        MODE_TIMEOUT = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    // Result event codes.
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_FRAME = 2'd1,
        EV_FAULT = 2'd2
    } event_t;

    // Register index, taken from paddr bit 2.
    typedef enum logic {
        REG_SYNC   = 1'b0,
        REG_QLIMIT = 1'b1
    } reg_idx_t;

endpackage

// File: rtl/sfp_if.sv
// ============================================================================
// sfp_if
// Valid/ready channels for input requests and result requests.
// ============================================================================
interface sfp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface sfp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_res;
    logic signed [21:0] voc_sum;
    logic [15:0]        voc_sample;
    logic [15:0]        temperature_centi;
    logic [15:0]        humidity_centi;
    logic               sensor_fault;
    logic [7:0]         missed_queries;

    modport source (output valid, output event_res, output voc_sum, output voc_sample,
                    output temperature_centi, output humidity_centi,
                    output sensor_fault, output missed_queries, input ready);
    modport sink   (input valid, input event_res, input voc_sum, input voc_sample,
                    input temperature_centi, input humidity_centi,
                    input sensor_fault, input missed_queries, output ready);
endinterface

// File: rtl/sensor_frame_parser_moving_sum.sv
// ============================================================================
// sensor_frame_parser_moving_sum
// Frame scanner over a byte stream with a moving sum of VOC samples.
// ============================================================================
// A result is shown in the cycle after its request is accepted.
// Throughput: one request per cycle while the output register is free or being taken.
// The byte window and sample ring are shift chains of cells; a running
// checksum register keeps the frame test to one add and compare per byte.
// Reset clears all state but the output data registers, sets sync_byte to 0xFF and query_limit to 15.
module sensor_frame_parser_moving_sum
    import sfp_pkg::*;
#(
    parameter int unsigned WINDOW_SAMPLES = WINDOW_SAMPLES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    sfp_in_if.sink            in_ch,
    sfp_out_if.source         out_ch
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [7:0] sync_reg,   sync_next;
    logic [7:0] qlimit_reg, qlimit_next;
    logic       cfg_wr;
    reg_idx_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        sync_next   = sync_reg;
        qlimit_next = qlimit_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SYNC:   sync_next   = pwdata[7:0];
                REG_QLIMIT: qlimit_next = pwdata[7:0];
                default:    sync_next   = sync_reg;
            endcase
        end
    end

    // Read data decode.
    always_comb
    begin
        unique case (cfg_idx)
            REG_SYNC:   prdata = {{(DATA_W-8){1'b0}}, sync_reg};
            REG_QLIMIT: prdata = {{(DATA_W-8){1'b0}}, qlimit_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg   <= SYNC_RESET;
            qlimit_reg <= QLIMIT_RESET;
        end
        else
        begin
            sync_reg   <= sync_next;
            qlimit_reg <= qlimit_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: accept whenever the output register is free or draining.
    // ------------------------------------------------------------------
    logic  out_valid_reg, out_valid_next;
    logic  in_acc;
    mode_t mode;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign mode        = mode_t'(in_ch.mode);

    logic byte_shift;
    assign byte_shift = in_acc && (mode == MODE_BYTE);

    // ------------------------------------------------------------------
    // Byte window: cell 0 holds the oldest byte (frame byte 0).
    // ------------------------------------------------------------------
    logic [7:0] win [FRAME_HIST];

    genvar gi;
    generate
        for (gi = 0; gi < FRAME_HIST; gi++)
        begin : g_byte
            logic [7:0] feed;
            if (gi == FRAME_HIST - 1)
            begin : g_last
                assign feed = in_ch.data_byte;
            end
            else
            begin : g_mid
                assign feed = win[gi+1];
            end
            sfp_cell #(.WIDTH(8)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (byte_shift),
                .din   (feed),
                .dout  (win[gi])
            );
        end
    endgenerate

    // Running checksum of window bytes 1..11 (mod 256).
    logic [7:0] csum_reg, csum_next;
    logic [7:0] csum_total;
    logic [3:0] skip_reg, skip_next;
    logic       frame_hit;
    logic       frame_take;

    assign csum_total = csum_reg + in_ch.data_byte;
    assign frame_hit  = (win[0] == sync_reg) && (csum_total == 8'd0);
    assign frame_take = byte_shift && (skip_reg == 4'd0) && frame_hit;

    always_comb
    begin
        csum_next = byte_shift ? (csum_total - win[1]) : csum_reg;
    end

    // ------------------------------------------------------------------
    // Sample ring: cell 0 holds the newest sample, the last cell the oldest.
    // ------------------------------------------------------------------
    logic [15:0] ring [WINDOW_SAMPLES];
    logic [15:0] new_sample;

    assign new_sample = {win[6], win[7]};

    generate
        for (gi = 0; gi < WINDOW_SAMPLES; gi++)
        begin : g_ring
            logic [15:0] feed;
            if (gi == 0)
            begin : g_first
                assign feed = new_sample;
            end
            else
            begin : g_rest
                assign feed = ring[gi-1];
            end
            sfp_cell #(.WIDTH(16)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (frame_take),
                .din   (feed),
                .dout  (ring[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Frame, query and timeout state.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] sum_reg,    sum_next;
    logic [15:0]      temp_reg,   temp_next;
    logic [15:0]      hum_reg,    hum_next;
    logic [7:0]       missed_reg, missed_next;
    logic             fault_reg,  fault_next;
    event_t           ev;

    always_comb
    begin
        skip_next   = skip_reg;
        sum_next    = sum_reg;
        temp_next   = temp_reg;
        hum_next    = hum_reg;
        missed_next = missed_reg;
        fault_next  = fault_reg;
        ev          = EV_NONE;
        if (in_acc)
        begin
            unique case (mode)
                MODE_BYTE:
                begin
                    if (skip_reg != 4'd0)
                    begin
                        skip_next = skip_reg - 4'd1;
                    end
                    else if (frame_hit)
                    begin
                        skip_next   = 4'(SKIP_LEN);
                        sum_next    = sum_reg + SUM_W'(new_sample)
                                      - SUM_W'(ring[WINDOW_SAMPLES-1]);
                        temp_next   = {win[8], win[9]};
                        hum_next    = {win[10], win[11]};
                        missed_next = 8'd0;
                        fault_next  = 1'b0;
                        ev          = EV_FRAME;
                    end
                end
                MODE_QUERY:
                begin
                    if (missed_reg != 8'hFF)
                    begin
                        missed_next = missed_reg + 8'd1;
                    end
                end
                MODE_TIMEOUT:
                begin
                    if (missed_reg >= qlimit_reg)
                    begin
                        sum_next   = '0;
                        temp_next  = '0;
                        hum_next   = '0;
                        fault_next = 1'b1;
                        ev         = EV_FAULT;
                    end
                end
                default:
                begin
                    ev = EV_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csum_reg   <= '0;
            skip_reg   <= '0;
            sum_reg    <= '0;
            temp_reg   <= '0;
            hum_reg    <= '0;
            missed_reg <= '0;
            fault_reg  <= 1'b0;
        end
        else
        begin
            csum_reg   <= csum_next;
            skip_reg   <= skip_next;
            sum_reg    <= sum_next;
            temp_reg   <= temp_next;
            hum_reg    <= hum_next;
            missed_reg <= missed_next;
            fault_reg  <= fault_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic [1:0]  ev_out_reg;
    logic [SUM_W-1:0] sum_out_reg;
    logic [15:0] sample_out_reg;
    logic [15:0] temp_out_reg;
    logic [15:0] hum_out_reg;
    logic        fault_out_reg;
    logic [7:0]  missed_out_reg;

    always_comb
    begin
        out_valid_next = in_acc || (out_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ev_out_reg     <= ev;
            sum_out_reg    <= sum_next;
            sample_out_reg <= frame_take ? new_sample : ring[0];
            temp_out_reg   <= temp_next;
            hum_out_reg    <= hum_next;
            fault_out_reg  <= fault_next;
            missed_out_reg <= missed_next;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.event_res         = ev_out_reg;
    assign out_ch.voc_sum           = $signed(sum_out_reg);
    assign out_ch.voc_sample        = sample_out_reg;
    assign out_ch.temperature_centi = temp_out_reg;
    assign out_ch.humidity_centi    = hum_out_reg;
    assign out_ch.sensor_fault      = fault_out_reg;
    assign out_ch.missed_queries    = missed_out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The untested-byte count never exceeds one frame's tail.
    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg <= 4'(SKIP_LEN))
        else $error("skip count out of range");

    // An accepted frame arms the skip count for the next twelve bytes.
    a_skip_armed: assert property (@(posedge clk) disable iff (!rst_n)
        frame_take |=> (skip_reg == 4'(SKIP_LEN)))
        else $error("skip count not armed after frame");

    // A frame result reports a cleared fault and miss count.
    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.event_res == EV_FRAME) |->
        (!out_ch.sensor_fault && out_ch.missed_queries == 8'd0))
        else $error("frame result with stale fault state");

    // A fault result reports zeroed readings and the fault flag.
    a_fault_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.event_res == EV_FAULT) |->
        (out_ch.sensor_fault && out_ch.voc_sum == '0 &&
         out_ch.temperature_centi == 16'd0 && out_ch.humidity_centi == 16'd0))
        else $error("fault result with live readings");

    // State only moves on an accepted request.
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> ($stable(sum_reg) && $stable(missed_reg) && $stable(skip_reg)))
        else $error("state changed without a request");

endmodule

// File: rtl/sfp_cell.sv
// ============================================================================
// sfp_cell
// One storage cell of a shift chain: loads its neighbor's value on a shift.
// ============================================================================
module sfp_cell
    import sfp_pkg::*;
#(
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] value_reg;
    logic [WIDTH-1:0] value_next;

    // Take the neighbor's value when the chain moves.
    always_comb
    begin
        value_next = shift ? din : value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign dout = value_reg;

endmodule

// File: test/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the sensor frame parser: byte, query, timeout and
// idle requests go in with random gaps, and every result is checked against
// a cycle-free model of the frame scan, the VOC ring and the fault logic.
// ============================================================================
import sfp_pkg::*;

// One expected or observed result request.
typedef struct {
    event_t             ev;
    logic signed [21:0] sum;
    logic [15:0]        sample;
    logic [15:0]        temp;
    logic [15:0]        hum;
    logic               fault;
    logic [7:0]         missed;
} reading_t;

// Tracks the parser state and holds the readings still to come out.
class reading_tracker;
    localparam int unsigned RING_N = WINDOW_SAMPLES_DEF;

    logic [7:0]  sync_val;
    logic [7:0]  limit_val;
    logic [7:0]  window[FRAME_HIST];
    int unsigned skip_left;
    logic [15:0] ring[RING_N];
    int unsigned ring_pos;
    logic [21:0] run_sum;
    logic [15:0] temp_reg;
    logic [15:0] hum_reg;
    logic [7:0]  missed;
    logic        fault;
    reading_t    pending_readings[$];
    int          mismatches;

    function new();
        sync_val  = SYNC_RESET;
        limit_val = QLIMIT_RESET;
        foreach (window[i]) window[i] = 8'h00;
        foreach (ring[i]) ring[i] = 16'h0000;
        skip_left  = 0;
        ring_pos   = 0;
        run_sum    = '0;
        temp_reg   = '0;
        hum_reg    = '0;
        missed     = '0;
        fault      = 1'b0;
        mismatches = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [7:0] value);
        if (idx == REG_SYNC)
            sync_val = value;
        else
            limit_val = value;
    endfunction

    // Advance the model by one accepted input request.
    function void note_request(mode_t m, logic [7:0] b);
        reading_t    exp;
        event_t      ev;
        logic [7:0]  csum;
        logic [7:0]  total;
        logic [15:0] v;
        logic [15:0] old;
        int unsigned last;
        ev = EV_NONE;
        case (m)
            MODE_BYTE:
            begin
                // The twelve held bytes and this one form the candidate frame.
                if (skip_left > 0) begin
                    skip_left--;
                end
                else if (window[0] == sync_val) begin
                    csum = 8'h00;
                    for (int i = 1; i <= 11; i++) csum = csum + window[i];
                    total = csum + b;
                    if (total == 8'h00) begin
                        v   = {window[6], window[7]};
                        old = ring[ring_pos];
                        run_sum = run_sum + {6'd0, v} - {6'd0, old};
                        ring[ring_pos] = v;
                        ring_pos = (ring_pos + 1 >= RING_N) ? 0 : ring_pos + 1;
                        temp_reg  = {window[8], window[9]};
                        hum_reg   = {window[10], window[11]};
                        missed    = 8'h00;
                        fault     = 1'b0;
                        skip_left = SKIP_LEN;
                        ev        = EV_FRAME;
                    end
                end
                for (int i = 0; i < FRAME_HIST - 1; i++) window[i] = window[i + 1];
                window[FRAME_HIST - 1] = b;
            end
            MODE_QUERY:
            begin
                if (missed != 8'hFF) missed++;
            end
            MODE_TIMEOUT:
            begin
                // The ring survives a fault; the sum, temperature and humidity restart at zero.
                if (missed >= limit_val) begin
                    temp_reg = '0;
                    hum_reg  = '0;
                    run_sum  = '0;
                    fault    = 1'b1;
                    ev       = EV_FAULT;
                end
            end
            default:
            begin
            end
        endcase
        last = (ring_pos == 0) ? RING_N - 1 : ring_pos - 1;
        exp.ev     = ev;
        exp.sum    = run_sum;
        exp.sample = ring[last];
        exp.temp   = temp_reg;
        exp.hum    = hum_reg;
        exp.fault  = fault;
        exp.missed = missed;
        pending_readings.push_back(exp);
    endfunction

    // Compare one result request with the oldest expected reading.
    function void check_reading(reading_t got);
        reading_t exp;
        if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: ev=%0d sum=%0d sample=%h", got.ev, got.sum,
                         got.sample);
            return;
        end
        exp = pending_readings.pop_front();
        if (got.ev !== exp.ev || got.sum !== exp.sum || got.sample !== exp.sample ||
            got.temp !== exp.temp || got.hum !== exp.hum || got.fault !== exp.fault ||
            got.missed !== exp.missed) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch expected: ev=%0d sum=%0d sample=%h temp=%h hum=%h f=%b m=%0d",
                         exp.ev, exp.sum, exp.sample, exp.temp, exp.hum, exp.fault,
                         exp.missed);
                $display("         actual:   ev=%0d sum=%0d sample=%h temp=%h hum=%h f=%b m=%0d",
                         got.ev, got.sum, got.sample, got.temp, got.hum, got.fault,
                         got.missed);
            end
        end
    endfunction

    function int pending();
        return pending_readings.size();
    endfunction

    function int failures();
        return mismatches;
    endfunction
endclass

module tb_top;

    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 400;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    sfp_in_if  in_ch();
    sfp_out_if out_ch();

    reading_tracker sb;
    logic [7:0]     cur_sync;
    int             items_sent;
    int             send_calm;
    int             cycle_count;
    bit             hold_request;

    sensor_frame_parser_moving_sum uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Clock.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Watchdog on the total run length.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sender gap: mostly none or short, a few long, with calm stretches.
    function automatic int pick_send_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            send_calm = $urandom_range(30, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick16();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Offer one input request and wait until it is taken.
    task automatic send_item(mode_t m, logic [7:0] b);
        int gap;
        gap = pick_send_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= m;
        in_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(m, b);
        if (m != MODE_NONE)
            items_sent++;
    endtask

    // Send a frame with the given payload; a corrupt one has a bad sync or checksum.
    task automatic send_frame(logic [15:0] voc, logic [15:0] t, logic [15:0] h, bit corrupt);
        logic [7:0] fb[13];
        logic [7:0] csum;
        fb[0] = cur_sync;
        for (int k = 1; k <= 5; k++)
            fb[k] = ($urandom_range(0, 9) == 0) ? cur_sync : 8'($urandom);
        fb[6]  = voc[15:8];
        fb[7]  = voc[7:0];
        fb[8]  = t[15:8];
        fb[9]  = t[7:0];
        fb[10] = h[15:8];
        fb[11] = h[7:0];
        csum = 8'h00;
        for (int k = 1; k <= 11; k++) csum = csum + fb[k];
        fb[12] = 8'h00 - csum;
        if (corrupt) begin
            if ($urandom_range(0, 1) == 0)
                fb[12] = fb[12] ^ (8'h01 << $urandom_range(0, 7));
            else
                fb[0] = fb[0] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (int k = 0; k < 13; k++) send_item(MODE_BYTE, fb[k]);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic apb_write(reg_idx_t idx, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering and wait until every expected reading has come out.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic configure(logic [7:0] sync_v, logic [7:0] limit_v);
        drain();
        apb_write(REG_SYNC, sync_v);
        apb_write(REG_QLIMIT, limit_v);
        cur_sync = sync_v;
    endtask

    // Mostly well-formed frames, mixed with noise, queries and timeout checks.
    task automatic run_random(int n);
        int target;
        int r;
        target = items_sent + n;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_frame(pick16(), pick16(), pick16(), 1'b0);
            else if (r < 65)
                send_frame(pick16(), pick16(), pick16(), 1'b1);
            else if (r < 75)
                repeat ($urandom_range(1, 6))
                    send_item(MODE_BYTE, ($urandom_range(0, 3) == 0) ? cur_sync
                                                                     : 8'($urandom));
            else if (r < 87)
                repeat ($urandom_range(1, 4)) send_item(MODE_QUERY, 8'($urandom));
            else if (r < 96)
                send_item(MODE_TIMEOUT, 8'($urandom));
            else
                send_item(MODE_NONE, 8'($urandom));
        end
    endtask

    // Result side: random ready, with a long hold-off on request.
    initial
    begin
        int       stall_left;
        int       calm_left;
        int       r;
        reading_t got;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        calm_left    = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                got.ev     = event_t'(out_ch.event_res);
                got.sum    = out_ch.voc_sum;
                got.sample = out_ch.voc_sample;
                got.temp   = out_ch.temperature_centi;
                got.hum    = out_ch.humidity_centi;
                got.fault  = out_ch.sensor_fault;
                got.missed = out_ch.missed_queries;
                sb.check_reading(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (calm_left > 0) begin
                out_ch.ready <= 1'b1;
                calm_left--;
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    calm_left    = $urandom_range(30, 60);
                    out_ch.ready <= 1'b1;
                end
                else if (r < 65) begin
                    out_ch.ready <= 1'b1;
                end
                else if (r < 95) begin
                    stall_left   = $urandom_range(0, 2);
                    out_ch.ready <= 1'b0;
                end
                else begin
                    stall_left   = $urandom_range(8, 40);
                    out_ch.ready <= 1'b0;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        sb           = new();
        items_sent   = 0;
        send_calm    = 0;
        hold_request = 1'b0;
        cur_sync     = SYNC_RESET;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.mode      <= MODE_BYTE;
        in_ch.data_byte <= 8'h00;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start-up: with a zero sync byte the cleared window plus a zero byte is a frame.
        configure(8'h00, QLIMIT_RESET);
        send_item(MODE_BYTE, 8'h00);

        // Extreme payload, queries, a timeout check below the limit, an ignored request.
        configure(8'hFF, 8'd15);
        send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_item(MODE_QUERY, 8'h00);
        send_item(MODE_QUERY, 8'hFF);
        send_item(MODE_TIMEOUT, 8'h5A);
        send_item(MODE_NONE, 8'hFF);

        // Fault declared, then declared again on the next check.
        configure(8'hFF, 8'd1);
        send_item(MODE_TIMEOUT, 8'h00);
        send_item(MODE_TIMEOUT, 8'hFF);

        // A zero limit faults on every check.
        configure(8'hFF, 8'd0);
        send_frame(16'h1234, 16'h0BB8, 16'h1770, 1'b0);
        send_item(MODE_TIMEOUT, 8'h00);

        // Random phases over several register settings.
        configure(8'hFF, 8'd15);
        hold_request = 1'b1;
        run_random(90);
        configure(8'h00, 8'd1);
        run_random(90);
        configure(8'($urandom), 8'd255);
        run_random(90);
        configure(8'hA5, 8'($urandom_range(1, 20)));
        hold_request = 1'b1;
        run_random(90);
        configure(8'($urandom), 8'd0);
        run_random(90);

        // Missed count saturates; the limit of 255 is then reached.
        configure(8'hFF, 8'd255);
        repeat (260) send_item(MODE_QUERY, 8'($urandom));
        send_item(MODE_TIMEOUT, 8'($urandom));
        run_random(60);

        drain();
        repeat (4) @(posedge clk);
        if (sb.failures() == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
